[hw/rtl/smnm_pkg.sv]
// shared constants, codes and helpers of the sorted multi-list node manager
`timescale 1ns / 1ps

package smnm_pkg;

    localparam int NODES    = 16;
    localparam int LISTS    = 16;
    localparam int KEY_BITS = 16;

    // port field widths
    localparam int OP_W     = 3;
    localparam int ID_W     = 5;
    localparam int KEYIN_W  = 16;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 5;

    // node numbers run 1..NODES, zero is the null link
    localparam int NODE_W = $clog2(NODES + 1);
    localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LIST_W = $clog2(LISTS + 1);
    localparam int LIDX_W = (LISTS > 1) ? $clog2(LISTS) : 1;

    typedef logic [NODE_W-1:0]          t_node;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic signed [KEY_BITS-1:0] t_key;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_COUNT   = 3'd3,
        OP_TOTAL   = 3'd4,
        OP_COMPACT = 3'd5,
        OP_NOP6    = 3'd6,
        OP_NOP7    = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_MEM   = 2'd1,
        ST_NO_LIST  = 2'd2,
        ST_NO_KEY   = 2'd3
    } t_status;

    // node number to store index
    function automatic t_idx node_idx(input t_node n);
        t_node m;
        m = n - t_node'(1);
        return m[IDX_W-1:0];
    endfunction

    // port key to stored key width, sign extended or truncated
    function automatic t_key key_in(input logic signed [KEYIN_W-1:0] k);
        logic signed [KEYIN_W+KEY_BITS-1:0] w;
        w = (KEYIN_W + KEY_BITS)'(k);
        return w[KEY_BITS-1:0];
    endfunction

endpackage

[hw/rtl/smnm_if.sv]
// valid/ready channels for commands and responses
`timescale 1ns / 1ps

interface smnm_in_if;
    import smnm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            opcode;
    logic [ID_W-1:0]            list_id;
    logic signed [KEYIN_W-1:0]  key;

    modport source (output valid, output opcode, output list_id, output key, input ready);
    modport sink   (input valid, input opcode, input list_id, input key, output ready);
endinterface

interface smnm_out_if;
    import smnm_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

[hw/rtl/sorted_multilist_node_manager.sv]
// top level of the sorted multi-list node manager
`timescale 1ns / 1ps

// Keeps up to LISTS ascending singly linked key lists in a store of NODES
// nodes with a LIFO free chain; one command in, one response out. The block
// handles one command at a time under a small sequencer that reads one node
// per cycle: create, total and unknown opcodes pass through the start state
// straight to the response, insert, delete and count first walk the node
// links of their list, and compaction scans every slot to rebuild the free
// chain in ascending slot order. Node slot numbers are never visible at the
// ports, so compaction keeps list nodes in place and only reorders the free
// chain. The response sits in an output register, so the next command is
// taken as soon as the sequencer is back in idle.
module sorted_multilist_node_manager
    import smnm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    smnm_in_if.sink     i_cmd,
    smnm_out_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS,
        S_DEL,
        S_CNT,
        S_CMP,
        S_RESP
    } t_state;

    t_state r_state;

    // node store and list heads
    t_key                r_key  [NODES];
    t_node               r_next [NODES];
    logic [NODES-1:0]    r_used;
    t_node               r_head [LISTS];
    t_node               r_free_head;
    t_node               r_free_cnt;
    t_node               r_used_cnt;
    logic [LIST_W-1:0]   r_lists;

    // latched command
    t_op                 r_op;
    logic [ID_W-1:0]     r_id;
    t_key                r_kin;

    // walk registers
    t_node               r_cur;
    t_node               r_prv;
    t_node               r_new;
    t_node               r_cnt;
    t_idx                r_slot;
    t_node               r_fh;
    logic [LIDX_W-1:0]   r_hidx;

    // pending response and output register
    t_status             r_st;
    logic [VALUE_W-1:0]  r_val;
    logic                r_ovalid;
    t_status             r_ostat;
    logic [VALUE_W-1:0]  r_oval;

    // combinational views
    logic                id_ok;
    logic [LIDX_W-1:0]   hidx;
    logic                have;
    t_idx                cur_i;
    t_idx                fh_i;
    t_idx                slot_node;
    t_node               slot_num;

    always_comb begin
        logic [ID_W-1:0] idm;
        idm   = r_id - ID_W'(1);
        id_ok = (r_id != '0) && (int'(r_id) <= LISTS);
        hidx  = LIDX_W'(idm);
        have  = id_ok && (r_head[hidx] != '0);
    end

    assign cur_i     = node_idx(r_cur);
    assign fh_i      = node_idx(r_free_head);
    assign slot_node = r_slot;
    assign slot_num  = t_node'(r_slot) + t_node'(1);

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.status = r_ostat;
    assign o_rsp.value  = r_oval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_free_head <= t_node'(1);
            r_free_cnt  <= t_node'(NODES);
            r_used_cnt  <= '0;
            r_lists     <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_next[i] <= (i + 1 < NODES) ? t_node'(i + 2) : '0;
            end
            for (int j = 0; j < LISTS; j++) begin
                r_head[j] <= '0;
            end
        end else begin
            // the response state reloads the output register itself
            if (o_rsp.valid && o_rsp.ready && r_state != S_RESP) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_op    <= t_op'(i_cmd.opcode);
                        r_id    <= i_cmd.list_id;
                        r_kin   <= key_in(i_cmd.key);
                        r_state <= S_START;
                    end
                end

                S_START: begin
                    r_hidx <= hidx;
                    case (r_op)
                        OP_CREATE: begin
                            r_state <= S_RESP;
                            if (int'(r_lists) >= LISTS || r_free_cnt == '0) begin
                                r_st  <= ST_NO_MEM;
                                r_val <= '0;
                            end else begin
                                // take the free head as the sole node of the new list
                                r_st           <= ST_OK;
                                r_free_head    <= r_next[fh_i];
                                r_used[fh_i]   <= 1'b1;
                                r_key[fh_i]    <= r_kin;
                                r_next[fh_i]   <= '0;
                                r_head[r_lists[LIDX_W-1:0]] <= r_free_head;
                                r_lists        <= r_lists + LIST_W'(1);
                                r_free_cnt     <= r_free_cnt - t_node'(1);
                                r_used_cnt     <= r_used_cnt + t_node'(1);
                                r_val          <= VALUE_W'(r_lists + LIST_W'(1));
                            end
                        end
                        OP_INSERT: begin
                            r_val <= '0;
                            if (!have) begin
                                r_st    <= ST_NO_LIST;
                                r_state <= S_RESP;
                            end else if (r_free_cnt == '0) begin
                                r_st    <= ST_NO_MEM;
                                r_state <= S_RESP;
                            end else begin
                                r_st         <= ST_OK;
                                r_new        <= r_free_head;
                                r_free_head  <= r_next[fh_i];
                                r_used[fh_i] <= 1'b1;
                                r_key[fh_i]  <= r_kin;
                                r_free_cnt   <= r_free_cnt - t_node'(1);
                                r_used_cnt   <= r_used_cnt + t_node'(1);
                                r_cur        <= r_head[hidx];
                                r_prv        <= '0;
                                r_state      <= S_INS;
                            end
                        end
                        OP_DELETE: begin
                            r_val <= '0;
                            if (!have) begin
                                r_st    <= ST_NO_LIST;
                                r_state <= S_RESP;
                            end else begin
                                r_st    <= ST_OK;
                                r_cur   <= r_head[hidx];
                                r_prv   <= '0;
                                r_state <= S_DEL;
                            end
                        end
                        OP_COUNT: begin
                            r_val <= '0;
                            if (!have) begin
                                r_st    <= ST_NO_LIST;
                                r_state <= S_RESP;
                            end else begin
                                r_st    <= ST_OK;
                                r_cur   <= r_head[hidx];
                                r_cnt   <= '0;
                                r_state <= S_CNT;
                            end
                        end
                        OP_TOTAL: begin
                            r_st    <= ST_OK;
                            r_val   <= VALUE_W'(r_used_cnt);
                            r_state <= S_RESP;
                        end
                        OP_COMPACT: begin
                            // scan slots from the top down
                            r_st    <= ST_OK;
                            r_val   <= '0;
                            r_slot  <= t_idx'(NODES - 1);
                            r_fh    <= '0;
                            r_state <= S_CMP;
                        end
                        default: begin
                            r_st    <= ST_OK;
                            r_val   <= '0;
                            r_state <= S_RESP;
                        end
                    endcase
                end

                S_INS: begin
                    // stop before the first larger key
                    if (r_cur == '0 || (r_kin < r_key[cur_i])) begin
                        r_next[node_idx(r_new)] <= r_cur;
                        if (r_prv != '0) begin
                            r_next[node_idx(r_prv)] <= r_new;
                        end else begin
                            r_head[r_hidx] <= r_new;
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_prv <= r_cur;
                        r_cur <= r_next[cur_i];
                    end
                end

                S_DEL: begin
                    if (r_cur == '0) begin
                        r_st    <= ST_NO_KEY;
                        r_state <= S_RESP;
                    end else if (r_key[cur_i] == r_kin) begin
                        // unlink, then push onto the free chain
                        if (r_prv != '0) begin
                            r_next[node_idx(r_prv)] <= r_next[cur_i];
                        end else begin
                            r_head[r_hidx] <= r_next[cur_i];
                        end
                        r_next[cur_i] <= r_free_head;
                        r_used[cur_i] <= 1'b0;
                        r_free_head   <= r_cur;
                        r_free_cnt    <= r_free_cnt + t_node'(1);
                        r_used_cnt    <= r_used_cnt - t_node'(1);
                        r_state       <= S_RESP;
                    end else begin
                        r_prv <= r_cur;
                        r_cur <= r_next[cur_i];
                    end
                end

                S_CNT: begin
                    if (r_cur == '0) begin
                        r_val   <= VALUE_W'(r_cnt);
                        r_state <= S_RESP;
                    end else begin
                        r_cnt <= r_cnt + t_node'(1);
                        r_cur <= r_next[cur_i];
                    end
                end

                S_CMP: begin
                    // link each unused slot ahead of the chain built so far
                    if (!r_used[slot_node]) begin
                        r_next[slot_node] <= r_fh;
                        r_fh              <= slot_num;
                    end
                    if (r_slot == '0) begin
                        r_free_head <= r_used[slot_node] ? r_fh : slot_num;
                        r_state     <= S_RESP;
                    end else begin
                        r_slot <= r_slot - t_idx'(1);
                    end
                end

                S_RESP: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= r_st;
                        r_oval   <= r_val;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
